@@ rtl/core/lphm_pkg.sv @@
package lphm_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd3;

  // remainder unit: bits retired per cycle
  localparam int MOD_STEPS = 4;
  localparam int MOD_CYCLES = KEY_W / MOD_STEPS;
  localparam int MOD_CNT_W = $clog2(MOD_CYCLES);

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_BADKEY   = 3'd5
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic key_we;
    logic val_we;
  } mem_cmd_t;

endpackage

@@ rtl/core/linear_probe_hash_map_core.sv @@
// a key of zero skips the remainder unit and the probe and goes straight to the result; any
// other key passes the key-modulo-size unit, then a read and a check for each probed slot
// throughput: one item at a time, set by the remainder unit and the single store port
// reset and each table_size write start a clearing pass over the first table_size slots of
// the key store, with no input taken meanwhile; after reset table_size is 3
module linear_probe_hash_map_core #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lphm_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [lphm_pkg::KEY_W-1:0]    key,
  input  logic [lphm_pkg::VAL_W-1:0]    new_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [lphm_pkg::VAL_W-1:0]    found_value,
  output logic                          load_high,
  output logic [lphm_pkg::SIZE_W-1:0]   slot_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((IDX_W > lphm_pkg::SIZE_W) ? IDX_W : lphm_pkg::SIZE_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                          state;
  logic [lphm_pkg::SIZE_W-1:0]     size;
  logic [lphm_pkg::SIZE_W-1:0]     size_next;
  logic [lphm_pkg::SIZE_W-1:0]     entry_count;
  logic [IDX_W-1:0]                clear_idx;
  logic [IDX_W-1:0]                probe_idx;
  logic [IDX_W-1:0]                probe_idx_next;
  logic [lphm_pkg::SIZE_W-1:0]     probe_n;
  lphm_pkg::op_t                   op;
  logic [lphm_pkg::KEY_W-1:0]      op_key;
  logic [lphm_pkg::VAL_W-1:0]      op_val;
  lphm_pkg::status_t               res_status;
  logic [lphm_pkg::VAL_W-1:0]      res_value;
  lphm_pkg::status_t               out_status;

  logic                            in_fire;
  logic                            mod_start;
  logic                            mod_done;
  logic [lphm_pkg::SIZE_W-1:0]     mod_rem;
  lphm_pkg::mem_cmd_t              mem_cmd;
  logic [IDX_W-1:0]                mem_addr;
  logic [lphm_pkg::KEY_W-1:0]      mem_wkey;
  logic [lphm_pkg::KEY_W-1:0]      key_q;
  logic [lphm_pkg::VAL_W-1:0]      val_q;
  logic                            slot_match;
  logic                            slot_empty;
  logic                            last_probe;
  logic [8:0]                      load_limit;
  logic                            load_high_next;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign mod_start = in_fire && (key != '0);

  // clamp the written size into 1..CAPACITY
  always_comb begin
    size_next = cfg_data;
    if (cfg_data == '0) begin
      size_next = lphm_pkg::SIZE_W'(1);
    end else if (CMP_W'(cfg_data) > CMP_W'(CAPACITY)) begin
      size_next = lphm_pkg::SIZE_W'(CAPACITY);
    end
  end

  assign slot_match = (key_q == op_key);
  assign slot_empty = (key_q == '0);
  assign last_probe = (CMP_W'(probe_n) + CMP_W'(1) == CMP_W'(size));

  always_comb begin
    if (CMP_W'(probe_idx) + CMP_W'(1) >= CMP_W'(size)) begin
      probe_idx_next = '0;
    end else begin
      probe_idx_next = probe_idx + 1'b1;
    end
  end

  always_comb begin
    mem_cmd  = '0;
    mem_addr = probe_idx;
    mem_wkey = op_key;
    if (state == S_CLEAR) begin
      mem_cmd.key_we = 1'b1;
      mem_addr = clear_idx;
      mem_wkey = '0;
    end else if (state == S_CHECK) begin
      if (op == lphm_pkg::OP_INSERT && slot_match) begin
        mem_cmd.val_we = 1'b1;
      end else if (op == lphm_pkg::OP_INSERT && slot_empty) begin
        mem_cmd.key_we = 1'b1;
        mem_cmd.val_we = 1'b1;
      end
    end
  end

  assign load_limit     = (9'(size) * 9'd3) >> 2;
  assign load_high_next = (9'(entry_count) > load_limit);

  lphm_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (key),
    .divisor   (size),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lphm_store #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wkey  (mem_wkey),
    .wval  (op_val),
    .key_q (key_q),
    .val_q (val_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      size        <= lphm_pkg::SIZE_RESET;
      entry_count <= '0;
      clear_idx   <= '0;
      out_valid   <= 1'b0;
    end else begin
      // a result leaving in the cycle a new one is loaded keeps valid high
      if (out_valid && out_ready && (cfg_write || state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        size        <= size_next;
        entry_count <= '0;
        clear_idx   <= '0;
        state       <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clear_idx <= clear_idx + 1'b1;
            if (CMP_W'(clear_idx) + CMP_W'(1) >= CMP_W'(size)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_fire) begin
              op        <= lphm_pkg::op_t'(operation);
              op_key    <= key;
              op_val    <= new_value;
              res_value <= '0;
              if (key == '0) begin
                res_status <= lphm_pkg::ST_BADKEY;
                state      <= S_DONE;
              end else begin
                res_status <= (operation == lphm_pkg::OP_INSERT) ?
                              lphm_pkg::ST_FULL : lphm_pkg::ST_NOTFOUND;
                state      <= S_DIV;
              end
            end
          end
          S_DIV: begin
            if (mod_done) begin
              probe_idx <= IDX_W'(mod_rem);
              probe_n   <= '0;
              state     <= S_READ;
            end
          end
          S_READ: begin
            state <= S_CHECK;
          end
          S_CHECK: begin
            if (slot_match) begin
              if (op == lphm_pkg::OP_INSERT) begin
                res_status <= lphm_pkg::ST_UPDATED;
              end else begin
                res_status <= lphm_pkg::ST_FOUND;
                res_value  <= val_q;
              end
              state <= S_DONE;
            end else if (slot_empty) begin
              if (op == lphm_pkg::OP_INSERT) begin
                res_status  <= lphm_pkg::ST_INSERTED;
                entry_count <= entry_count + 1'b1;
              end else begin
                res_status <= lphm_pkg::ST_NOTFOUND;
              end
              state <= S_DONE;
            end else if (last_probe) begin
              state <= S_DONE;
            end else begin
              probe_idx <= probe_idx_next;
              probe_n   <= probe_n + 1'b1;
              state     <= S_READ;
            end
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid   <= 1'b1;
              out_status  <= res_status;
              found_value <= res_value;
              load_high   <= load_high_next;
              slot_count  <= entry_count;
              state       <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign status = out_status;

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CHECK) |-> (CMP_W'(probe_idx) < CMP_W'(size)))
    else $error("probe index beyond table size");

  a_count_within_size: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(entry_count) <= CMP_W'(size))
    else $error("entry count exceeds table size");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    (size != '0) && (CMP_W'(size) <= CMP_W'(CAPACITY)))
    else $error("table size out of range");

  a_value_only_on_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != lphm_pkg::ST_FOUND) |-> (found_value == '0))
    else $error("value reported without a hit");

endmodule

@@ rtl/core/lphm_mod.sv @@
module lphm_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lphm_pkg::KEY_W-1:0]    dividend,
  input  logic [lphm_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [lphm_pkg::SIZE_W-1:0]   remainder
);

  logic                            busy;
  logic [lphm_pkg::MOD_CNT_W-1:0]  cnt;
  logic [lphm_pkg::KEY_W-1:0]      sh;
  logic [lphm_pkg::SIZE_W-1:0]     rem;
  logic [lphm_pkg::SIZE_W-1:0]     dsr;
  logic [lphm_pkg::KEY_W-1:0]      sh_next;
  logic [lphm_pkg::SIZE_W-1:0]     rem_next;

  // restoring remainder, several bits per cycle
  always_comb begin
    logic [lphm_pkg::SIZE_W:0] t;
    rem_next = rem;
    sh_next = sh;
    t = '0;
    for (int i = 0; i < lphm_pkg::MOD_STEPS; i++) begin
      t = {rem_next, sh_next[lphm_pkg::KEY_W-1]};
      sh_next = {sh_next[lphm_pkg::KEY_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        rem_next = lphm_pkg::SIZE_W'(t - {1'b0, dsr});
      end else begin
        rem_next = t[lphm_pkg::SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        sh   <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        sh  <= sh_next;
        cnt <= cnt + 1'b1;
        if (cnt == lphm_pkg::MOD_CNT_W'(lphm_pkg::MOD_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dsr))
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a running division");

endmodule

@@ rtl/core/lphm_store.sv @@
module lphm_store #(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6
) (
  input  logic                        clk,
  input  lphm_pkg::mem_cmd_t          cmd,
  input  logic [IDX_W-1:0]            addr,
  input  logic [lphm_pkg::KEY_W-1:0]  wkey,
  input  logic [lphm_pkg::VAL_W-1:0]  wval,
  output logic [lphm_pkg::KEY_W-1:0]  key_q,
  output logic [lphm_pkg::VAL_W-1:0]  val_q
);

  logic [lphm_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [lphm_pkg::VAL_W-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.key_we) begin
      key_mem[addr] <= wkey;
    end
    key_q <= key_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      val_mem[addr] <= wval;
    end
    val_q <= val_mem[addr];
  end

endmodule

@@ test/linear_probe_hash_map_core_test.sv @@
`timescale 1ns / 100ps

module linear_probe_hash_map_core_test;

  localparam int TABLE_CAP = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    lphm_pkg::status_t                stat;
    logic [lphm_pkg::VAL_W-1:0]       value;
    logic                             heavy;
    logic [lphm_pkg::SIZE_W-1:0]      used;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [lphm_pkg::SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [lphm_pkg::KEY_W-1:0] key = '0;
  logic [lphm_pkg::VAL_W-1:0] new_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [lphm_pkg::VAL_W-1:0] found_value;
  logic load_high;
  logic [lphm_pkg::SIZE_W-1:0] slot_count;

  // table mirror
  logic [lphm_pkg::KEY_W-1:0] slot_key [TABLE_CAP];
  logic [lphm_pkg::VAL_W-1:0] slot_val [TABLE_CAP];
  int unsigned fill_count = 0;
  int unsigned live_size = 32'(lphm_pkg::SIZE_RESET);

  reply_t pending_replies [$];
  logic [lphm_pkg::KEY_W-1:0] phase_keys [$];
  int mismatches = 0;
  int cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  linear_probe_hash_map_core #(.CAPACITY(TABLE_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .key(key),
    .new_value(new_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_value(found_value),
    .load_high(load_high),
    .slot_count(slot_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void clear_mirror();
    for (int i = 0; i < TABLE_CAP; i++) slot_key[i] = '0;
    fill_count = 0;
  endfunction

  function automatic reply_t probe_table(lphm_pkg::op_t op,
                                         logic [lphm_pkg::KEY_W-1:0] k,
                                         logic [lphm_pkg::VAL_W-1:0] v);
    reply_t r;
    int unsigned idx;
    bit done;
    r.value = '0;
    if (k == '0) begin
      r.stat = lphm_pkg::ST_BADKEY;
    end else begin
      idx = k % live_size;
      r.stat = (op == lphm_pkg::OP_INSERT) ? lphm_pkg::ST_FULL : lphm_pkg::ST_NOTFOUND;
      done = 1'b0;
      for (int unsigned n = 0; n < live_size && !done; n++) begin
        if (slot_key[idx] == k) begin
          if (op == lphm_pkg::OP_INSERT) begin
            slot_val[idx] = v;
            r.stat = lphm_pkg::ST_UPDATED;
          end else begin
            r.value = slot_val[idx];
            r.stat = lphm_pkg::ST_FOUND;
          end
          done = 1'b1;
        end else if (slot_key[idx] == '0) begin
          if (op == lphm_pkg::OP_INSERT) begin
            slot_key[idx] = k;
            slot_val[idx] = v;
            fill_count++;
            r.stat = lphm_pkg::ST_INSERTED;
          end else begin
            r.stat = lphm_pkg::ST_NOTFOUND;
          end
          done = 1'b1;
        end else begin
          idx = (idx + 1 == live_size) ? 0 : idx + 1;
        end
      end
    end
    r.heavy = fill_count > (live_size * 3) / 4;
    r.used = fill_count[lphm_pkg::SIZE_W-1:0];
    return r;
  endfunction

  // reply checker
  always @(posedge clk) begin : check_reply
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("result with no item waiting: status %0d", status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, status);
          mismatches++;
        end
        if (found_value !== want.value) begin
          $error("found_value: expected %h, got %h", want.value, found_value);
          mismatches++;
        end
        if (load_high !== want.heavy) begin
          $error("load_high: expected %0d, got %0d", want.heavy, load_high);
          mismatches++;
        end
        if (slot_count !== want.used) begin
          $error("slot_count: expected %0d, got %0d", want.used, slot_count);
          mismatches++;
        end
      end
    end
  end

  // result side
  initial begin : result_sink
    int stall;
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1 && rx_hold == 0) @(posedge clk);
    end
  end

  task automatic send_beat(input lphm_pkg::op_t op, input logic [lphm_pkg::KEY_W-1:0] k,
                           input logic [lphm_pkg::VAL_W-1:0] v);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    key <= k;
    new_value <= v;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_replies.push_back(probe_table(op, k, v));
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_size(input logic [lphm_pkg::SIZE_W-1:0] raw);
    wait_all_replies();
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= raw;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (raw == 0) live_size = 1;
    else if (raw > TABLE_CAP) live_size = TABLE_CAP;
    else live_size = 32'(raw);
    clear_mirror();
    phase_keys.delete();
  endtask

  function automatic logic [lphm_pkg::KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 44 && phase_keys.size() != 0)
      return phase_keys[$urandom_range(0, phase_keys.size() - 1)];
    if (roll < 74)
      return live_size * $urandom_range(0, 5000) + $urandom_range(0, live_size - 1);
    return $urandom();
  endfunction

  task automatic run_phase(input logic [lphm_pkg::SIZE_W-1:0] raw, input int count,
                           input int ins_pct);
    logic [lphm_pkg::KEY_W-1:0] k;
    lphm_pkg::op_t op;
    set_size(raw);
    for (int i = 0; i < count; i++) begin
      k = pick_key();
      op = ($urandom_range(0, 99) < ins_pct) ? lphm_pkg::OP_INSERT : lphm_pkg::OP_LOOKUP;
      if (k != '0) begin
        phase_keys.push_back(k);
        if (phase_keys.size() > 200) void'(phase_keys.pop_front());
      end
      send_beat(op, k, $urandom());
    end
  endtask

  task automatic test_default_size();
    send_beat(lphm_pkg::OP_INSERT, 32'd0, 32'hFFFF_FFFF);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd0, 32'd0);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd5, 32'd0);
    send_beat(lphm_pkg::OP_INSERT, 32'd3, 32'd0);
    send_beat(lphm_pkg::OP_INSERT, 32'd6, 32'hFFFF_FFFF);
    send_beat(lphm_pkg::OP_INSERT, 32'd2, 32'h5A5A_5A5A);
    send_beat(lphm_pkg::OP_INSERT, 32'd9, 32'hA5A5_A5A5);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd6, 32'd0);
    send_beat(lphm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    send_beat(lphm_pkg::OP_INSERT, 32'd6, 32'h1234_5678);
  endtask

  task automatic test_size_extremes();
    set_size(7'd0);
    send_beat(lphm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'd1);
    send_beat(lphm_pkg::OP_INSERT, 32'd7, 32'd2);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd7, 32'd0);
    send_beat(lphm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0);
    set_size(7'd127);
    send_beat(lphm_pkg::OP_INSERT, 32'd63, 32'h0000_0063);
    // wraps from the last slot to slot zero
    send_beat(lphm_pkg::OP_INSERT, 32'd127, 32'h0000_0127);
    send_beat(lphm_pkg::OP_INSERT, 32'd64, 32'h0000_0064);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd64, 32'd0);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd191, 32'd0);
    send_beat(lphm_pkg::OP_LOOKUP, 32'h8000_0000, 32'd0);
    set_size(7'd64);
    send_beat(lphm_pkg::OP_INSERT, 32'hFFFF_FFC0, 32'd0);
    set_size(7'd1);
    send_beat(lphm_pkg::OP_INSERT, 32'd1, 32'h8000_0001);
    send_beat(lphm_pkg::OP_LOOKUP, 32'd1, 32'd0);
  endtask

  task automatic test_backpressure();
    logic [lphm_pkg::KEY_W-1:0] k;
    set_size(7'd16);
    tx_idle = 1'b0;
    rx_hold = 300;
    for (int i = 0; i < 30; i++) begin
      k = $urandom_range(1, 40);
      send_beat((i % 3 == 2) ? lphm_pkg::OP_LOOKUP : lphm_pkg::OP_INSERT, k, $urandom());
    end
    wait_all_replies();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [lphm_pkg::SIZE_W-1:0] raw;
    for (int p = 0; p < 12; p++) begin
      tx_idle = (p % 3 != 1);
      rx_idle = (p % 4 != 2);
      if (p == 0) raw = 7'd64;
      else if (p == 1) raw = 7'd0;
      else if (p == 2) raw = 7'd127;
      else if (p % 5 == 0) raw = lphm_pkg::SIZE_W'($urandom_range(65, 127));
      else raw = lphm_pkg::SIZE_W'($urandom_range(1, 20));
      if (p == 0 || p == 2) run_phase(raw, 140, 90);
      else run_phase(raw, 60, $urandom_range(40, 80));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    clear_mirror();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (8) @(posedge clk);
    test_default_size();
    test_size_extremes();
    test_backpressure();
    test_random_traffic();
    wait_all_replies();
    repeat (160) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lphm_pkg.sv
rtl/core/lphm_mod.sv
rtl/core/lphm_store.sv
rtl/core/linear_probe_hash_map_core.sv
test/linear_probe_hash_map_core_test.sv
